/* src/linear_probe_hash_table_macros.svh */
// assertion macros for the checker file
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define LPHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on the rising clock, off during reset
`define LPHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/lpht_pkg.sv */
// ----------------------------------------------------------------------------
// lpht_pkg
// Types and constants of the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int SLOTS_DEFAULT         = 16;
  localparam int PAYLOAD_WIDTH_DEFAULT = 32;
  localparam int MAX_PAYLOAD_WIDTH     = 64;

  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int OP_WIDTH    = 2;
  localparam int CFG_WIDTH   = 5;
  localparam int CFG_MAX     = 31;
  localparam int CFG_RESET   = 16;

  // modulo unit takes two key bits per step
  localparam int DIV_STEPS  = KEY_WIDTH / 2;
  localparam int DIV_STEP_W = $clog2(DIV_STEPS);

  localparam logic [OP_WIDTH-1:0] OP_PUT    = 2'd0;
  localparam logic [OP_WIDTH-1:0] OP_GET    = 2'd1;
  localparam logic [OP_WIDTH-1:0] OP_REMOVE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_PROBE,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

endpackage

/* src/linear_probe_hash_table.sv */
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open addressing key/payload table with linear probing, one request at a time.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  request   in         req_valid / req_stall  opcode, key, value_in
//  response  out        rsp_valid / rsp_stall  ok, value_out
//  config    in         cfg_valid / cfg_ready  slots_in_use
//
//  a request runs from accept to response through the 2-bit-a-step modulo unit
//  for the start slot, then n reads of the key/payload table (one read port,
//  one write port), n the active slots, then the drain and commit states.
//  an unused opcode skips the modulo unit and the probe and goes straight to commit.
//  reset clears the valid bits at once, no clearing pass; the slot count
//  returns to 16 (limited to SLOTS).
//  the response register holds under rsp_stall; the next request is taken
//  while a response waits, and its commit waits until the register is free.
// ----------------------------------------------------------------------------
module linear_probe_hash_table import lpht_pkg::*; #(
  parameter int SLOTS         = SLOTS_DEFAULT,
  parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  logic [OP_WIDTH-1:0]    opcode,
  input  logic [KEY_WIDTH-1:0]   key,
  input  logic [VALUE_WIDTH-1:0] value_in,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output logic                   ok,
  output logic [VALUE_WIDTH-1:0] value_out,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_WIDTH-1:0]   slots_in_use
);

  // the slot count register cannot reach past CFG_MAX slots
  localparam int DEPTH     = (SLOTS < CFG_MAX) ? SLOTS : CFG_MAX;
  localparam int AW        = $clog2(DEPTH);
  localparam int RESET_CNT = (SLOTS < CFG_RESET) ? SLOTS : CFG_RESET;
  localparam int TW        = CFG_WIDTH + 2;

  typedef logic [PAYLOAD_WIDTH-1:0] payload_t;

  state_t state, state_next;

  logic [CFG_WIDTH-1:0]   cfg_slots;
  logic [CFG_WIDTH-1:0]   act_n;

  logic [OP_WIDTH-1:0]    op_q;
  logic [KEY_WIDTH-1:0]   key_q;
  payload_t               pay_q;
  logic [CFG_WIDTH-1:0]   n_q;
  logic [KEY_WIDTH-1:0]   dividend;
  logic [CFG_WIDTH-1:0]   rem;
  logic [CFG_WIDTH-1:0]   rem_next;
  logic [DIV_STEP_W-1:0]  step;
  logic [AW-1:0]          cur;
  logic [CFG_WIDTH-1:0]   left;

  logic [DEPTH-1:0]       vld;
  logic [KEY_WIDTH-1:0]   key_mem [DEPTH];
  payload_t               pay_mem [DEPTH];
  logic [KEY_WIDTH-1:0]   rd_key;
  payload_t               rd_pay;
  logic                   rd_vld;
  logic [AW-1:0]          rd_idx;
  logic                   pv;

  logic                   hit_found;
  logic [AW-1:0]          hit_idx;
  logic [VALUE_WIDTH-1:0] hit_value;
  logic                   empty_found;
  logic [AW-1:0]          empty_idx;

  logic                   accept;
  logic                   out_free;
  logic                   commit_fire;
  logic                   issue;
  logic                   put_ok;
  logic [AW-1:0]          dst;
  logic                   ok_next;
  logic [VALUE_WIDTH-1:0] value_next;

  logic [TW-1:0]          t;
  logic [TW-1:0]          n1;
  logic [TW-1:0]          n2;
  logic [TW-1:0]          n3;
  logic [TW-1:0]          t_red;
  logic [CFG_WIDTH:0]     cur_inc;
  logic [MAX_PAYLOAD_WIDTH-1:0] in_wide;
  logic [MAX_PAYLOAD_WIDTH-1:0] rd_wide;

  assign accept      = req_valid && !req_stall;
  assign out_free    = !rsp_valid || !rsp_stall;
  assign commit_fire = (state == ST_COMMIT) && out_free;

  always_comb begin
    if (cfg_slots == '0) begin
      act_n = CFG_WIDTH'(1);
    end else if (cfg_slots > CFG_WIDTH'(DEPTH)) begin
      act_n = CFG_WIDTH'(DEPTH);
    end else begin
      act_n = cfg_slots;
    end
  end

  // one remainder step: r = (4r + two key bits) mod n
  always_comb begin
    t  = {rem, dividend[KEY_WIDTH-1 -: 2]};
    n1 = TW'(n_q);
    n2 = n1 << 1;
    n3 = n2 + n1;
    if (t >= n3) begin
      t_red = t - n3;
    end else if (t >= n2) begin
      t_red = t - n2;
    end else if (t >= n1) begin
      t_red = t - n1;
    end else begin
      t_red = t;
    end
    rem_next = t_red[CFG_WIDTH-1:0];
  end

  assign cur_inc = {1'b0, CFG_WIDTH'(cur)} + (CFG_WIDTH + 1)'(1);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (opcode == OP_PUT || opcode == OP_GET || opcode == OP_REMOVE) begin
            state_next = ST_DIVIDE;
          end else begin
            state_next = ST_COMMIT;
          end
        end
      end
      ST_DIVIDE: begin
        if (step == DIV_STEP_W'(DIV_STEPS - 1)) begin
          state_next = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (left == CFG_WIDTH'(1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_stall = 1'b1;
    cfg_ready = 1'b0;
    issue     = 1'b0;
    case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        cfg_ready = 1'b1;
      end
      ST_PROBE: begin
        issue = 1'b1;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  // commit decision
  always_comb begin
    put_ok     = 1'b0;
    dst        = hit_found ? hit_idx : empty_idx;
    ok_next    = 1'b0;
    value_next = '0;
    case (op_q)
      OP_PUT: begin
        put_ok  = hit_found || empty_found;
        ok_next = put_ok;
      end
      OP_GET: begin
        ok_next    = hit_found;
        value_next = hit_found ? hit_value : '0;
      end
      OP_REMOVE: begin
        ok_next = hit_found;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  assign in_wide = MAX_PAYLOAD_WIDTH'(value_in);
  assign rd_wide = MAX_PAYLOAD_WIDTH'(rd_pay);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cfg_slots <= CFG_WIDTH'(RESET_CNT);
      vld       <= '0;
      rsp_valid <= 1'b0;
      pv        <= 1'b0;
    end else begin
      state <= state_next;
      pv    <= issue;
      if (cfg_valid && cfg_ready) begin
        cfg_slots <= slots_in_use;
      end
      if (commit_fire) begin
        if (put_ok) begin
          vld[dst] <= 1'b1;
        end else if (op_q == OP_REMOVE && hit_found) begin
          vld[hit_idx] <= 1'b0;
        end
      end
      if (commit_fire) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q        <= opcode;
      key_q       <= key;
      pay_q       <= in_wide[PAYLOAD_WIDTH-1:0];
      n_q         <= act_n;
      dividend    <= key;
      rem         <= '0;
      step        <= '0;
      hit_found   <= 1'b0;
      empty_found <= 1'b0;
    end
    if (state == ST_DIVIDE) begin
      dividend <= dividend << 2;
      rem      <= rem_next;
      step     <= step + DIV_STEP_W'(1);
      if (step == DIV_STEP_W'(DIV_STEPS - 1)) begin
        cur  <= rem_next[AW-1:0];
        left <= n_q;
      end
    end
    if (issue) begin
      left <= left - CFG_WIDTH'(1);
      if (cur_inc >= {1'b0, n_q}) begin
        cur <= '0;
      end else begin
        cur <= cur_inc[AW-1:0];
      end
    end
    rd_vld <= vld[cur];
    rd_idx <= cur;
    // compare the slot read in the previous cycle
    if (pv) begin
      if (rd_vld && rd_key == key_q && !hit_found) begin
        hit_found <= 1'b1;
        hit_idx   <= rd_idx;
        hit_value <= rd_wide[VALUE_WIDTH-1:0];
      end
      if (!rd_vld && !empty_found) begin
        empty_found <= 1'b1;
        empty_idx   <= rd_idx;
      end
    end
    if (commit_fire) begin
      ok        <= ok_next;
      value_out <= value_next;
    end
  end

  // key and payload table
  always_ff @(posedge clk) begin
    if (commit_fire && put_ok) begin
      key_mem[dst] <= key_q;
      pay_mem[dst] <= pay_q;
    end
    rd_key <= key_mem[cur];
    rd_pay <= pay_mem[cur];
  end

endmodule

/* src/lpht_checker.sv */
// ----------------------------------------------------------------------------
// lpht_checker
// Port-level checks of the hash table, bound to the top level.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_table_macros.svh"

module lpht_checker import lpht_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   req_valid,
  input logic                   req_stall,
  input logic                   rsp_valid,
  input logic                   rsp_stall,
  input logic                   ok,
  input logic [VALUE_WIDTH-1:0] value_out,
  input logic                   cfg_ready
);

  logic req_fire;

  assign req_fire = req_valid && !req_stall;

  // a request keeps the block busy for at least the next cycle
  `LPHT_ASSERT_NEXT(busy_after_request, req_fire, req_stall, "request not held busy")

  // a stalled response stays up
  `LPHT_ASSERT_NEXT(rsp_held, rsp_valid && rsp_stall, rsp_valid, "response dropped under stall")

  // only a found get carries a payload
  `LPHT_ASSERT_NOW(value_zero_on_miss, rsp_valid && !ok, value_out == '0, "payload on miss")

  // config writes are only taken while no request is in work
  `LPHT_ASSERT_NOW(cfg_only_idle, req_stall, !cfg_ready, "config ready while busy")

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);
